// ===== rtl/rmts_pkg.sv =====
// Shared types and constants for the rate monotonic tick scheduler.
// No dependencies; imported by rmts_ctrl and the top level.
`default_nettype none

package rmts_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int EXEC_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int WORK_W   = 16;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;
  // Wide enough to compare slot numbers and counts against table depths up to 127.
  localparam int WIDE_W   = 7;

  localparam int TASK_W = EXEC_W + PERIOD_W;
  localparam int DYN_W  = WORK_W + TIME_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/rmts_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing; instantiated for the task table and the schedule state.
`default_nettype none

module rmts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rmts_ctrl.sv =====
// Scan sequencer and datapath: walks the task slots through both RAMs,
// releases tasks, picks the shortest-period ready task and writes state back.
// Depends on rmts_pkg.
`default_nettype none

module rmts_ctrl #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
  parameter int IW        = $clog2(MAX_TASKS),
  parameter int CW        = $clog2(MAX_TASKS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        opcode,
  input  wire logic [rmts_pkg::SLOT_W-1:0]   slot,
  input  wire logic [rmts_pkg::EXEC_W-1:0]   exec_time,
  input  wire logic [rmts_pkg::PERIOD_W-1:0] period,
  input  wire logic                        cfg_we,
  input  wire logic [rmts_pkg::COUNT_W-1:0]  cfg_data,
  output logic                             done,
  output logic                             idle,
  output logic      [rmts_pkg::SLOT_W-1:0]   running_task,
  output logic      [rmts_pkg::TIME_W-1:0]   tick_number,
  output logic      [IW-1:0]               rd_addr,
  output logic                             task_we,
  output logic      [IW-1:0]               task_waddr,
  output logic      [rmts_pkg::TASK_W-1:0]   task_wdata,
  input  wire logic [rmts_pkg::TASK_W-1:0]   task_rdata,
  output logic                             dyn_we,
  output logic      [IW-1:0]               dyn_waddr,
  output logic      [rmts_pkg::DYN_W-1:0]    dyn_wdata,
  input  wire logic [rmts_pkg::DYN_W-1:0]    dyn_rdata
);

  import rmts_pkg::*;

  state_t state, state_next;

  logic [CW-1:0]       scan_idx;
  logic [CW-1:0]       n_lim;
  logic                pipe_vld;
  logic [IW-1:0]       pipe_idx;
  logic [MAX_TASKS-1:0] dyn_valid;
  logic                found;
  logic [IW-1:0]       best;
  logic [PERIOD_W-1:0] best_period;
  logic [WORK_W-1:0]   best_work;
  logic [TIME_W-1:0]   best_rel;
  logic [TIME_W-1:0]   tick_counter;
  logic [COUNT_W-1:0]  task_count;

  logic                accept;
  logic                issue;
  logic [WIDE_W-1:0]   slot_wide;
  logic                slot_in_range;
  logic [WIDE_W-1:0]   count_wide;
  logic [CW-1:0]       n_next;

  logic [WORK_W-1:0]   cur_work;
  logic [TIME_W-1:0]   cur_rel;
  logic [EXEC_W-1:0]   cur_exec;
  logic [PERIOD_W-1:0] cur_period;
  logic                released;
  logic [WORK_W:0]     work_sum;
  logic [WORK_W-1:0]   work_new;
  logic [TIME_W-1:0]   rel_new;
  logic                better;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign issue  = (state == ST_SCAN) && (scan_idx < n_lim);

  assign slot_wide     = WIDE_W'(slot);
  assign slot_in_range = slot_wide < WIDE_W'(MAX_TASKS);
  assign count_wide    = WIDE_W'(task_count);
  assign n_next = (count_wide > WIDE_W'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(task_count);

  // Entries not written since the last load read as zero.
  assign cur_work   = dyn_valid[pipe_idx] ? dyn_rdata[DYN_W-1 -: WORK_W] : '0;
  assign cur_rel    = dyn_valid[pipe_idx] ? dyn_rdata[TIME_W-1:0] : '0;
  assign cur_exec   = task_rdata[TASK_W-1 -: EXEC_W];
  assign cur_period = task_rdata[PERIOD_W-1:0];

  always_comb begin
    released = (cur_rel == tick_counter);
    work_sum = {1'b0, cur_work} + {1'b0, cur_exec};
    if (released) begin
      work_new = work_sum[WORK_W] ? '1 : work_sum[WORK_W-1:0];
      rel_new  = cur_rel + TIME_W'(cur_period);
    end else begin
      work_new = cur_work;
      rel_new  = cur_rel;
    end
    // Strict compare keeps the lowest slot on equal periods.
    better = (work_new != '0) && (!found || (cur_period < best_period));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_TICK)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !pipe_vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_addr    = scan_idx[IW-1:0];
    task_we    = accept && (opcode == OP_LOAD) && slot_in_range;
    task_waddr = slot_wide[IW-1:0];
    task_wdata = {exec_time, period};
    dyn_we     = 1'b0;
    dyn_waddr  = pipe_idx;
    dyn_wdata  = {work_new, rel_new};
    case (state)
      ST_SCAN: begin
        dyn_we = pipe_vld;
      end
      ST_FINISH: begin
        // The winner runs one tick; its release time is already up to date.
        dyn_we    = found;
        dyn_waddr = best;
        dyn_wdata = {best_work - WORK_W'(1), best_rel};
      end
      default: begin
        dyn_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_idx     <= '0;
      n_lim        <= '0;
      pipe_vld     <= 1'b0;
      found        <= 1'b0;
      dyn_valid    <= '0;
      tick_counter <= '0;
      task_count   <= COUNT_W'(1);
      done         <= 1'b0;
    end else begin
      state    <= state_next;
      pipe_vld <= issue;
      done     <= (state == ST_FINISH);
      if (cfg_we) begin
        task_count <= cfg_data;
      end
      if (accept) begin
        scan_idx <= '0;
        n_lim    <= n_next;
        found    <= 1'b0;
      end else if (issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (state == ST_SCAN && pipe_vld && better) begin
        found <= 1'b1;
      end
      if (accept && (opcode == OP_LOAD)) begin
        dyn_valid    <= '0;
        tick_counter <= '0;
      end else begin
        if (dyn_we) begin
          dyn_valid[dyn_waddr] <= 1'b1;
        end
        if (state == ST_FINISH) begin
          tick_counter <= tick_counter + TIME_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= scan_idx[IW-1:0];
    if (state == ST_SCAN && pipe_vld && better) begin
      best        <= pipe_idx;
      best_period <= cur_period;
      best_work   <= work_new;
      best_rel    <= rel_new;
    end
    if (state == ST_FINISH) begin
      idle         <= !found;
      running_task <= found ? SLOT_W'(best) : '0;
      tick_number  <= tick_counter;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rate_monotonic_tick_scheduler.sv =====
// Rate monotonic tick scheduler: a tick beat scans n = min(task_count, MAX_TASKS)
// slots and ends with the done strobe; busy stays high while the scan runs and falls
// as done rises. The scan reads one slot a cycle from the task and schedule RAMs.
// A load beat gives no result. The receiver cannot stall.
// Synchronous reset: task_count = 1, tick counter and schedule state cleared.
`default_nettype none

module rate_monotonic_tick_scheduler #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode,
  input  wire logic [rmts_pkg::SLOT_W-1:0]   slot,
  input  wire logic [rmts_pkg::EXEC_W-1:0]   exec_time,
  input  wire logic [rmts_pkg::PERIOD_W-1:0] period,
  input  wire logic                          cfg_we,
  input  wire logic [rmts_pkg::COUNT_W-1:0]  cfg_data,
  output logic                               done,
  output logic                               idle,
  output logic      [rmts_pkg::SLOT_W-1:0]   running_task,
  output logic      [rmts_pkg::TIME_W-1:0]   tick_number
);

  import rmts_pkg::*;

  localparam int IW = $clog2(MAX_TASKS);

  logic [IW-1:0]     rd_addr;
  logic              task_we;
  logic [IW-1:0]     task_waddr;
  logic [TASK_W-1:0] task_wdata;
  logic [TASK_W-1:0] task_rdata;
  logic              dyn_we;
  logic [IW-1:0]     dyn_waddr;
  logic [DYN_W-1:0]  dyn_wdata;
  logic [DYN_W-1:0]  dyn_rdata;

  // Execution time and period per slot.
  rmts_ram #(
    .WIDTH (TASK_W),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .raddr (rd_addr),
    .rdata (task_rdata)
  );

  // Remaining work and next release time per slot.
  rmts_ram #(
    .WIDTH (DYN_W),
    .DEPTH (MAX_TASKS)
  ) u_dyn_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (dyn_waddr),
    .wdata (dyn_wdata),
    .raddr (rd_addr),
    .rdata (dyn_rdata)
  );

  rmts_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .slot         (slot),
    .exec_time    (exec_time),
    .period       (period),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .done         (done),
    .idle         (idle),
    .running_task (running_task),
    .tick_number  (tick_number),
    .rd_addr      (rd_addr),
    .task_we      (task_we),
    .task_waddr   (task_waddr),
    .task_wdata   (task_wdata),
    .task_rdata   (task_rdata),
    .dyn_we       (dyn_we),
    .dyn_waddr    (dyn_waddr),
    .dyn_wdata    (dyn_wdata),
    .dyn_rdata    (dyn_rdata)
  );

endmodule

`default_nettype wire
